// ===== sv/cit_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cit_pkg
// Widths, codes, pipeline types and step functions shared by the circle
// intersection and tangent-point unit and its channel interfaces.
// ----------------------------------------------------------------------------
package cit_pkg;

	localparam int CW    = 32;          // coordinate width
	localparam int RW    = 31;          // radius width
	localparam int HW    = 32;          // half word for split multiplies
	localparam int AW    = CW + 1;      // delta magnitude
	localparam int DDW   = 2 * AW;      // squared distance
	localparam int KW    = 64;          // scale factors, square root result
	localparam int NUMW  = KW + AW - 1; // numerator before rounding
	localparam int NW    = NUMW + 2;    // 2*num + den
	localparam int DENW  = DDW + 1;
	localparam int DVW   = DENW + 1;    // 2*den
	localparam int QW    = 34;          // quotient bits kept
	localparam int RADW  = 2 * KW;
	localparam int SREMW = KW + 1;
	localparam int SUMW  = QW + 3;
	localparam int SQRT_STEPS = KW;
	localparam int DIV_STEPS  = QW;

	localparam logic OP_INTERSECT = 1'b0;
	localparam logic OP_TANGENT   = 1'b1;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic                 op;
		logic [1:0]           count;
		logic                 use_o;
		logic                 use_m;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic                 sox;
		logic                 soy;
		logic                 smx;
		logic                 smy;
		logic [AW-1:0]        adx;
		logic [AW-1:0]        ady;
		logic [DENW-1:0]      den;
		logic [RW-1:0]        r0;
	} ctx_t;

	typedef struct packed {
		logic [DVW:0]  rem;
		logic [QW-1:0] nb;
		logic [QW-1:0] q;
	} div_t;

	typedef struct packed {
		logic [RADW-1:0]  rad;
		logic [SREMW-1:0] rem;
		logic [KW-1:0]    root;
	} sqrt_t;

	typedef struct packed {
		ctx_t  ctx;
		sqrt_t sq;
		div_t  dox;
		div_t  doy;
	} mid_t;

	typedef struct packed {
		ctx_t          ctx;
		logic [QW-1:0] qox;
		logic [QW-1:0] qoy;
		div_t          dmx;
		div_t          dmy;
	} pdv_t;

	// rounding numerator n = 2*num + den, quotient known to fit in QW bits
	function automatic div_t div_init(input logic [NW-1:0] n);
		div_t y;
		y.rem = (DVW+1)'(n[NW-1:QW]);
		y.nb  = n[QW-1:0];
		y.q   = '0;
		return y;
	endfunction

	function automatic div_t div_step(input div_t x, input logic [DVW-1:0] d);
		logic [DVW:0] r;
		div_t         y;
		r    = {x.rem[DVW-1:0], x.nb[QW-1]};
		y.nb = {x.nb[QW-2:0], 1'b0};
		if (r >= {1'b0, d}) begin
			y.rem = r - {1'b0, d};
			y.q   = {x.q[QW-2:0], 1'b1};
		end else begin
			y.rem = r;
			y.q   = {x.q[QW-2:0], 1'b0};
		end
		return y;
	endfunction

	// one result bit per step, two radicand bits consumed
	function automatic sqrt_t sqrt_step(input sqrt_t x);
		logic [SREMW+1:0] r;
		logic [KW+1:0]    t;
		sqrt_t            y;
		r     = {x.rem, x.rad[RADW-1 -: 2]};
		t     = {x.root, 2'b01};
		y.rad = {x.rad[RADW-3:0], 2'b00};
		if (r >= (SREMW+2)'(t)) begin
			y.rem  = SREMW'(r - (SREMW+2)'(t));
			y.root = {x.root[KW-2:0], 1'b1};
		end else begin
			y.rem  = SREMW'(r);
			y.root = {x.root[KW-2:0], 1'b0};
		end
		return y;
	endfunction

	function automatic logic signed [QW:0] sval(input logic use_it, input logic neg,
			input logic [QW-1:0] q);
		logic signed [QW:0] m;
		m = signed'({1'b0, q});
		if (!use_it)
			m = '0;
		else if (neg)
			m = -m;
		return m;
	endfunction

	function automatic logic signed [CW-1:0] sat32(input logic signed [SUMW-1:0] v);
		logic signed [CW-1:0] r;
		if (v[SUMW-1:CW-1] == '0 || v[SUMW-1:CW-1] == '1)
			r = v[CW-1:0];
		else if (v[SUMW-1])
			r = SAT_MIN;
		else
			r = SAT_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cit_query_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cit_query_if
// Query channel: opcode and two circles, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cit_query_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [cit_pkg::CW-1:0] first_x;
	logic signed [cit_pkg::CW-1:0] first_y;
	logic [cit_pkg::RW-1:0]        first_radius;
	logic signed [cit_pkg::CW-1:0] second_x;
	logic signed [cit_pkg::CW-1:0] second_y;
	logic [cit_pkg::RW-1:0]        second_radius;

	modport source(output valid, opcode, first_x, first_y, first_radius,
		second_x, second_y, second_radius, input ready);
	modport sink(input valid, opcode, first_x, first_y, first_radius,
		second_x, second_y, second_radius, output ready);
endinterface
`default_nettype wire

// ===== sv/cit_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cit_result_if
// Result channel: point count and two points, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cit_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    point_count;
	logic signed [cit_pkg::CW-1:0] first_point_x;
	logic signed [cit_pkg::CW-1:0] first_point_y;
	logic signed [cit_pkg::CW-1:0] second_point_x;
	logic signed [cit_pkg::CW-1:0] second_point_y;

	modport source(output valid, point_count, first_point_x, first_point_y,
		second_point_x, second_point_y, input ready);
	modport sink(input valid, point_count, first_point_x, first_point_y,
		second_point_x, second_point_y, output ready);
endinterface
`default_nettype wire

// ===== sv/circle_intersection_and_tangents_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circle_intersection_and_tangents_unit
// Circle-circle intersection and tangent points from an outside point,
// exact integer math on Q16.16 codes, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one query per clock while the result side keeps up and returns the
// results in query order. The depth is set by the 64-step bit-per-stage square
// root followed by 34-bit restoring dividers for the offset terms; the base
// terms divide alongside the square root. When the result side stalls, the
// whole pipeline holds; a query can still be taken into an empty first
// stage. Points are rounded to nearest (ties away from zero) and saturated;
// with no solution all point fields are zero.
module circle_intersection_and_tangents_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	cit_query_if.sink            query,
	cit_result_if.source         result
);

	localparam int CW   = cit_pkg::CW;
	localparam int RW   = cit_pkg::RW;
	localparam int HW   = cit_pkg::HW;
	localparam int AW   = cit_pkg::AW;
	localparam int DDW  = cit_pkg::DDW;
	localparam int KW   = cit_pkg::KW;
	localparam int NUMW = cit_pkg::NUMW;
	localparam int NW   = cit_pkg::NW;
	localparam int DENW = cit_pkg::DENW;
	localparam int QW   = cit_pkg::QW;
	localparam int RADW = cit_pkg::RADW;
	localparam int SUMW = cit_pkg::SUMW;
	localparam int NSQ  = cit_pkg::SQRT_STEPS;
	localparam int NDV  = cit_pkg::DIV_STEPS;

	logic en;
	logic out_valid_q;

	// stage 1: deltas and magnitudes
	logic signed [AW-1:0] dx_c, dy_c;
	logic                 v_s1, op_s1, nx_s1, ny_s1;
	logic signed [CW-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic [RW-1:0]        r0_s1, r1_s1, dif_s1;
	logic [AW-1:0]        adx_s1, ady_s1;
	logic [CW-1:0]        sum_s1;

	// stage 2: squares
	logic                 v_s2, op_s2, nx_s2, ny_s2;
	logic signed [CW-1:0] x0_s2, y0_s2, x1_s2, y1_s2;
	logic [RW-1:0]        r0_s2;
	logic [AW-1:0]        adx_s2, ady_s2;
	logic [DDW-1:0]       adx2_s2, ady2_s2;
	logic [2*RW-1:0]      r0sq_s2, r1sq_s2, difsq_s2;
	logic [KW-1:0]        sumsq_s2;

	// stage 3: squared distance
	logic [DDW-1:0]       dd_c;
	logic                 v_s3, op_s3, nx_s3, ny_s3;
	logic signed [CW-1:0] x0_s3, y0_s3, x1_s3, y1_s3;
	logic [RW-1:0]        r0_s3;
	logic [AW-1:0]        adx_s3, ady_s3;
	logic [2*RW-1:0]      r0sq_s3, r1sq_s3, difsq_s3;
	logic [KW-1:0]        sumsq_s3;
	logic [DDW-1:0]       dd_s3;
	logic [KW:0]          pos_s3;

	// stage 4: case decisions and factors
	logic                 valid0_c, tang0_c, aneg_c, eq1_c, gt1_c;
	logic [KW:0]          mag_c;
	cit_pkg::ctx_t        ctx_c;
	logic [KW-1:0]        k_c, u_c, w_c;
	logic [DDW-1:0]       rad1_c;
	logic                 v_s4;
	cit_pkg::ctx_t        ctx_s4;
	logic [KW-1:0]        k_s4, u_s4, w_s4;
	logic [DDW-1:0]       rad1_s4;

	// stage 5: partial products
	logic                 v_s5;
	cit_pkg::ctx_t        ctx_s5;
	logic [DDW-1:0]       rad1_s5;
	logic [KW-1:0]        pll_s5, plh_s5, phl_s5, phh_s5;
	logic [KW:0]          kxl_s5, kxh_s5, kyl_s5, kyh_s5;

	// stage 6: partial sums
	logic                 v_s6;
	cit_pkg::ctx_t        ctx_s6;
	logic [DDW-1:0]       rad1_s6;
	logic [KW-1:0]        pll_s6, phh_s6;
	logic [KW:0]          pmid_s6;
	logic [NUMW-1:0]      numx_s6, numy_s6;

	// square root and base dividers
	cit_pkg::mid_t        mid_s   [0:NSQ];
	logic                 mid_v_s [0:NSQ];

	// post square root
	logic                 v_t1, v_t2, v_t3;
	cit_pkg::ctx_t        ctx_t1, ctx_t2, ctx_t3;
	logic [QW-1:0]        qox_t1, qoy_t1, qox_t2, qoy_t2, qox_t3, qoy_t3;
	logic [KW-1:0]        l_t1;
	logic [KW:0]          lyl_t2, lyh_t2, lxl_t2, lxh_t2;
	logic [NUMW-1:0]      nmx_t3, nmy_t3;

	// offset dividers
	cit_pkg::pdv_t        dv_s   [0:NDV];
	logic                 dv_v_s [0:NDV];

	// output
	cit_pkg::pdv_t             fin_c;
	logic signed [QW:0]        sox_c, soy_c, smx_c, smy_c;
	logic signed [SUMW-1:0]    fx_c, fy_c, sx_c, sy_c;
	logic [1:0]                point_count_q;
	logic signed [CW-1:0]      first_point_x_q, first_point_y_q;
	logic signed [CW-1:0]      second_point_x_q, second_point_y_q;

	assign en          = !out_valid_q || result.ready;
	assign query.ready = en || !v_s1;

	// ---------------------------------------------------------------- valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_t1        <= 1'b0;
			v_t2        <= 1'b0;
			v_t3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (query.ready)
				v_s1 <= query.valid;
			if (en) begin
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				v_s4        <= v_s3;
				v_s5        <= v_s4;
				v_s6        <= v_s5;
				v_t1        <= mid_v_s[NSQ];
				v_t2        <= v_t1;
				v_t3        <= v_t2;
				out_valid_q <= dv_v_s[NDV];
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	assign dx_c = AW'(query.second_x) - AW'(query.first_x);
	assign dy_c = AW'(query.second_y) - AW'(query.first_y);

	always_ff @(posedge clk) begin
		if (query.ready) begin
			op_s1  <= query.opcode;
			x0_s1  <= query.first_x;
			y0_s1  <= query.first_y;
			x1_s1  <= query.second_x;
			y1_s1  <= query.second_y;
			r0_s1  <= query.first_radius;
			r1_s1  <= query.second_radius;
			nx_s1  <= dx_c[AW-1];
			ny_s1  <= dy_c[AW-1];
			adx_s1 <= dx_c[AW-1] ? AW'(-dx_c) : AW'(dx_c);
			ady_s1 <= dy_c[AW-1] ? AW'(-dy_c) : AW'(dy_c);
			sum_s1 <= CW'(query.first_radius) + CW'(query.second_radius);
			dif_s1 <= (query.first_radius > query.second_radius) ?
				query.first_radius - query.second_radius :
				query.second_radius - query.first_radius;
		end
	end

	// ---------------------------------------------------------------- stages 2..6
	assign dd_c = adx2_s2 + ady2_s2;

	always_comb begin : s4_logic
		valid0_c = (dd_s3 != '0) && (dd_s3 <= DDW'(sumsq_s3)) && (dd_s3 >= DDW'(difsq_s3));
		tang0_c  = (dd_s3 == DDW'(sumsq_s3)) || (dd_s3 == DDW'(difsq_s3));
		aneg_c   = pos_s3 < (KW+1)'(r1sq_s3);
		mag_c    = aneg_c ? (KW+1)'(r1sq_s3) - pos_s3 : pos_s3 - (KW+1)'(r1sq_s3);
		eq1_c    = dd_s3 == DDW'(r0sq_s3);
		gt1_c    = dd_s3 > DDW'(r0sq_s3);
		u_c      = sumsq_s3 - dd_s3[KW-1:0];
		w_c      = dd_s3[KW-1:0] - KW'(difsq_s3);
		rad1_c   = dd_s3 - DDW'(r0sq_s3);

		ctx_c.op    = op_s3;
		ctx_c.count = cit_pkg::CNT_NONE;
		ctx_c.use_o = 1'b0;
		ctx_c.use_m = 1'b0;
		ctx_c.bx    = x0_s3;
		ctx_c.by    = y0_s3;
		ctx_c.smx   = !ny_s3;
		ctx_c.smy   = nx_s3;
		ctx_c.adx   = adx_s3;
		ctx_c.ady   = ady_s3;
		ctx_c.r0    = r0_s3;
		if (op_s3 == cit_pkg::OP_INTERSECT) begin
			ctx_c.sox = nx_s3 ^ aneg_c;
			ctx_c.soy = ny_s3 ^ aneg_c;
			ctx_c.den = DENW'({dd_s3[KW-1:0], 1'b0});
			k_c       = mag_c[KW-1:0];
			if (valid0_c) begin
				ctx_c.use_o = 1'b1;
				if (tang0_c) begin
					ctx_c.count = cit_pkg::CNT_ONE;
				end else begin
					ctx_c.count = cit_pkg::CNT_TWO;
					ctx_c.use_m = 1'b1;
				end
			end
		end else begin
			ctx_c.sox = nx_s3;
			ctx_c.soy = ny_s3;
			ctx_c.den = DENW'(dd_s3);
			k_c       = KW'(r0sq_s3);
			if (eq1_c) begin
				// point on the circle: the point itself
				ctx_c.count = cit_pkg::CNT_ONE;
				ctx_c.bx    = x1_s3;
				ctx_c.by    = y1_s3;
			end else if (gt1_c && r0_s3 == '0) begin
				ctx_c.count = cit_pkg::CNT_ONE;
			end else if (gt1_c) begin
				ctx_c.count = cit_pkg::CNT_TWO;
				ctx_c.use_o = 1'b1;
				ctx_c.use_m = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2    <= op_s1;
			x0_s2    <= x0_s1;
			y0_s2    <= y0_s1;
			x1_s2    <= x1_s1;
			y1_s2    <= y1_s1;
			r0_s2    <= r0_s1;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;
			adx_s2   <= adx_s1;
			ady_s2   <= ady_s1;
			adx2_s2  <= DDW'(adx_s1) * DDW'(adx_s1);
			ady2_s2  <= DDW'(ady_s1) * DDW'(ady_s1);
			r0sq_s2  <= (2*RW)'(r0_s1) * (2*RW)'(r0_s1);
			r1sq_s2  <= (2*RW)'(r1_s1) * (2*RW)'(r1_s1);
			difsq_s2 <= (2*RW)'(dif_s1) * (2*RW)'(dif_s1);
			sumsq_s2 <= KW'(sum_s1) * KW'(sum_s1);

			op_s3    <= op_s2;
			x0_s3    <= x0_s2;
			y0_s3    <= y0_s2;
			x1_s3    <= x1_s2;
			y1_s3    <= y1_s2;
			r0_s3    <= r0_s2;
			nx_s3    <= nx_s2;
			ny_s3    <= ny_s2;
			adx_s3   <= adx_s2;
			ady_s3   <= ady_s2;
			r0sq_s3  <= r0sq_s2;
			r1sq_s3  <= r1sq_s2;
			difsq_s3 <= difsq_s2;
			sumsq_s3 <= sumsq_s2;
			dd_s3    <= dd_c;
			pos_s3   <= (KW+1)'(r0sq_s2) + (KW+1)'(dd_c[KW-1:0]);

			ctx_s4   <= ctx_c;
			k_s4     <= k_c;
			u_s4     <= u_c;
			w_s4     <= w_c;
			rad1_s4  <= rad1_c;

			ctx_s5   <= ctx_s4;
			rad1_s5  <= rad1_s4;
			pll_s5   <= KW'(u_s4[HW-1:0]) * KW'(w_s4[HW-1:0]);
			plh_s5   <= KW'(u_s4[HW-1:0]) * KW'(w_s4[KW-1:HW]);
			phl_s5   <= KW'(u_s4[KW-1:HW]) * KW'(w_s4[HW-1:0]);
			phh_s5   <= KW'(u_s4[KW-1:HW]) * KW'(w_s4[KW-1:HW]);
			kxl_s5   <= (KW+1)'(k_s4[HW-1:0]) * (KW+1)'(ctx_s4.adx);
			kxh_s5   <= (KW+1)'(k_s4[KW-1:HW]) * (KW+1)'(ctx_s4.adx);
			kyl_s5   <= (KW+1)'(k_s4[HW-1:0]) * (KW+1)'(ctx_s4.ady);
			kyh_s5   <= (KW+1)'(k_s4[KW-1:HW]) * (KW+1)'(ctx_s4.ady);

			ctx_s6   <= ctx_s5;
			rad1_s6  <= rad1_s5;
			pll_s6   <= pll_s5;
			phh_s6   <= phh_s5;
			pmid_s6  <= (KW+1)'(plh_s5) + (KW+1)'(phl_s5);
			numx_s6  <= NUMW'(kxl_s5) + (NUMW'(kxh_s5) << HW);
			numy_s6  <= NUMW'(kyl_s5) + (NUMW'(kyh_s5) << HW);
		end
	end

	// ---------------------------------------------------------------- square root
	for (genvar k = 0; k <= NSQ; k++) begin : g_mid
		if (k == 0) begin : g_entry
			logic [RADW-1:0] prod_c;
			assign prod_c = RADW'(pll_s6) + (RADW'(pmid_s6) << HW) + (RADW'(phh_s6) << KW);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					mid_v_s[k] <= 1'b0;
				else if (en)
					mid_v_s[k] <= v_s6;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					mid_s[k].ctx     <= ctx_s6;
					mid_s[k].sq.rad  <= (ctx_s6.op == cit_pkg::OP_INTERSECT) ?
						prod_c : RADW'(rad1_s6);
					mid_s[k].sq.rem  <= '0;
					mid_s[k].sq.root <= '0;
					mid_s[k].dox     <= cit_pkg::div_init((NW'(numx_s6) << 1) + NW'(ctx_s6.den));
					mid_s[k].doy     <= cit_pkg::div_init((NW'(numy_s6) << 1) + NW'(ctx_s6.den));
				end
			end
		end else begin : g_step
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					mid_v_s[k] <= 1'b0;
				else if (en)
					mid_v_s[k] <= mid_v_s[k-1];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					mid_s[k].ctx <= mid_s[k-1].ctx;
					mid_s[k].sq  <= cit_pkg::sqrt_step(mid_s[k-1].sq);
					// base-term dividers share the first stages
					if (k <= NDV) begin
						mid_s[k].dox <= cit_pkg::div_step(mid_s[k-1].dox,
							{mid_s[k-1].ctx.den, 1'b0});
						mid_s[k].doy <= cit_pkg::div_step(mid_s[k-1].doy,
							{mid_s[k-1].ctx.den, 1'b0});
					end else begin
						mid_s[k].dox <= mid_s[k-1].dox;
						mid_s[k].doy <= mid_s[k-1].doy;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- offset numerators
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_t1 <= mid_s[NSQ].ctx;
			qox_t1 <= mid_s[NSQ].dox.q;
			qoy_t1 <= mid_s[NSQ].doy.q;
			l_t1   <= (mid_s[NSQ].ctx.op == cit_pkg::OP_INTERSECT) ? mid_s[NSQ].sq.root :
				KW'(mid_s[NSQ].ctx.r0) * KW'(mid_s[NSQ].sq.root[AW-1:0]);

			ctx_t2 <= ctx_t1;
			qox_t2 <= qox_t1;
			qoy_t2 <= qoy_t1;
			lyl_t2 <= (KW+1)'(l_t1[HW-1:0]) * (KW+1)'(ctx_t1.ady);
			lyh_t2 <= (KW+1)'(l_t1[KW-1:HW]) * (KW+1)'(ctx_t1.ady);
			lxl_t2 <= (KW+1)'(l_t1[HW-1:0]) * (KW+1)'(ctx_t1.adx);
			lxh_t2 <= (KW+1)'(l_t1[KW-1:HW]) * (KW+1)'(ctx_t1.adx);

			ctx_t3 <= ctx_t2;
			qox_t3 <= qox_t2;
			qoy_t3 <= qoy_t2;
			nmx_t3 <= NUMW'(lyl_t2) + (NUMW'(lyh_t2) << HW);
			nmy_t3 <= NUMW'(lxl_t2) + (NUMW'(lxh_t2) << HW);
		end
	end

	// ---------------------------------------------------------------- offset dividers
	for (genvar k = 0; k <= NDV; k++) begin : g_dv
		if (k == 0) begin : g_entry
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_v_s[k] <= 1'b0;
				else if (en)
					dv_v_s[k] <= v_t3;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k].ctx <= ctx_t3;
					dv_s[k].qox <= qox_t3;
					dv_s[k].qoy <= qoy_t3;
					dv_s[k].dmx <= cit_pkg::div_init((NW'(nmx_t3) << 1) + NW'(ctx_t3.den));
					dv_s[k].dmy <= cit_pkg::div_init((NW'(nmy_t3) << 1) + NW'(ctx_t3.den));
				end
			end
		end else begin : g_step
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_v_s[k] <= 1'b0;
				else if (en)
					dv_v_s[k] <= dv_v_s[k-1];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k].ctx <= dv_s[k-1].ctx;
					dv_s[k].qox <= dv_s[k-1].qox;
					dv_s[k].qoy <= dv_s[k-1].qoy;
					dv_s[k].dmx <= cit_pkg::div_step(dv_s[k-1].dmx, {dv_s[k-1].ctx.den, 1'b0});
					dv_s[k].dmy <= cit_pkg::div_step(dv_s[k-1].dmy, {dv_s[k-1].ctx.den, 1'b0});
				end
			end
		end
	end

	// ---------------------------------------------------------------- output
	assign fin_c = dv_s[NDV];
	assign sox_c = cit_pkg::sval(fin_c.ctx.use_o, fin_c.ctx.sox, fin_c.qox);
	assign soy_c = cit_pkg::sval(fin_c.ctx.use_o, fin_c.ctx.soy, fin_c.qoy);
	assign smx_c = cit_pkg::sval(fin_c.ctx.use_m, fin_c.ctx.smx, fin_c.dmx.q);
	assign smy_c = cit_pkg::sval(fin_c.ctx.use_m, fin_c.ctx.smy, fin_c.dmy.q);
	assign fx_c  = SUMW'(fin_c.ctx.bx) + SUMW'(sox_c) + SUMW'(smx_c);
	assign fy_c  = SUMW'(fin_c.ctx.by) + SUMW'(soy_c) + SUMW'(smy_c);
	assign sx_c  = SUMW'(fin_c.ctx.bx) + SUMW'(sox_c) - SUMW'(smx_c);
	assign sy_c  = SUMW'(fin_c.ctx.by) + SUMW'(soy_c) - SUMW'(smy_c);

	always_ff @(posedge clk) begin
		if (en) begin
			point_count_q <= fin_c.ctx.count;
			if (fin_c.ctx.count == cit_pkg::CNT_NONE) begin
				first_point_x_q  <= '0;
				first_point_y_q  <= '0;
				second_point_x_q <= '0;
				second_point_y_q <= '0;
			end else begin
				first_point_x_q  <= cit_pkg::sat32(fx_c);
				first_point_y_q  <= cit_pkg::sat32(fy_c);
				second_point_x_q <= cit_pkg::sat32(sx_c);
				second_point_y_q <= cit_pkg::sat32(sy_c);
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.point_count    = point_count_q;
	assign result.first_point_x  = first_point_x_q;
	assign result.first_point_y  = first_point_y_q;
	assign result.second_point_x = second_point_x_q;
	assign result.second_point_y = second_point_y_q;

	// ---------------------------------------------------------------- checks
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.point_count == cit_pkg::CNT_NONE) |->
		(result.first_point_x == '0 && result.first_point_y == '0 &&
		 result.second_point_x == '0 && result.second_point_y == '0))
		else $error("no-solution result carries nonzero points");

	a_single_same: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.point_count == cit_pkg::CNT_ONE) |->
		(result.second_point_x == result.first_point_x &&
		 result.second_point_y == result.first_point_y))
		else $error("single-point result has two different points");

	a_count_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.point_count == cit_pkg::CNT_NONE ||
		result.point_count == cit_pkg::CNT_ONE || result.point_count == cit_pkg::CNT_TWO))
		else $error("point count out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en) |-> (!query.ready ##1 v_s1))
		else $error("first stage dropped a query during a stall");

endmodule
`default_nettype wire

// ===== tb/tb_circle_intersection_and_tangents_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_circle_intersection_and_tangents_unit
// Queries the circle unit with directed corner cases and random circles
// (mostly with the second centre close to the first), predicts each result with
// exact wide integer math and compares the returned points field by field.
// ----------------------------------------------------------------------------
module tb_circle_intersection_and_tangents_unit;

	typedef struct packed {
		logic                          opcode;
		logic signed [cit_pkg::CW-1:0] x0;
		logic signed [cit_pkg::CW-1:0] y0;
		logic [cit_pkg::RW-1:0]        r0;
		logic signed [cit_pkg::CW-1:0] x1;
		logic signed [cit_pkg::CW-1:0] y1;
		logic [cit_pkg::RW-1:0]        r1;
	} query_t;

	typedef struct packed {
		logic [1:0]                    cnt;
		logic signed [cit_pkg::CW-1:0] p0x;
		logic signed [cit_pkg::CW-1:0] p0y;
		logic signed [cit_pkg::CW-1:0] p1x;
		logic signed [cit_pkg::CW-1:0] p1y;
	} points_t;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cit_query_if  query ();
	cit_result_if result ();

	circle_intersection_and_tangents_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query),
		.result(result)
	);

	always #6 clk = ~clk;

	query_t  pending_queries[$];
	points_t expected_points[$];
	int      errors = 0;
	bit      stim_done = 1'b0;
	bit      calm = 1'b0;
	bit      held = 1'b0;
	int      hold_cycles = 0;
	int      idle_count = 0;

	// round(num/den), ties away from zero, then sign
	function automatic logic signed [127:0] rdiv(input bit neg,
			input logic [255:0] num, input logic [255:0] den);
		logic [255:0] q;
		q = (2 * num + den) / (2 * den);
		return neg ? -$signed(q[127:0]) : $signed(q[127:0]);
	endfunction

	function automatic logic [127:0] isqrt(input logic [255:0] n);
		logic [127:0] res;
		logic [127:0] c;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if ({128'd0, c} * c <= n)
				res = c;
		end
		return res;
	endfunction

	function automatic logic signed [cit_pkg::CW-1:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return cit_pkg::SAT_MAX;
		if (v < -128'sd2147483648)
			return cit_pkg::SAT_MIN;
		return v[cit_pkg::CW-1:0];
	endfunction

	function automatic points_t solve_circles(input query_t q);
		logic signed [127:0] dx, dy, bx, by, ox, oy, mx, my;
		logic [255:0] adx, ady, dd, s2, df2, r0, r1, den, sq, mag;
		bit nx, ny, aneg;
		points_t p;
		dx = 128'(q.x1) - 128'(q.x0);
		dy = 128'(q.y1) - 128'(q.y0);
		nx = dx < 0;
		ny = dy < 0;
		adx = nx ? 256'(-dx) : 256'(dx);
		ady = ny ? 256'(-dy) : 256'(dy);
		dd = adx * adx + ady * ady;
		r0 = 256'(q.r0);
		r1 = 256'(q.r1);
		bx = 128'(q.x0);
		by = 128'(q.y0);
		ox = 0; oy = 0; mx = 0; my = 0;
		p = '0;
		p.cnt = cit_pkg::CNT_NONE;
		if (q.opcode == cit_pkg::OP_INTERSECT) begin
			s2 = (r0 + r1) * (r0 + r1);
			df2 = (r0 > r1) ? (r0 - r1) * (r0 - r1) : (r1 - r0) * (r1 - r0);
			if (dd != 0 && dd <= s2 && dd >= df2) begin
				aneg = r0 * r0 + dd < r1 * r1;
				mag = aneg ? r1 * r1 - r0 * r0 - dd : r0 * r0 + dd - r1 * r1;
				den = 2 * dd;
				ox = rdiv(nx != aneg, mag * adx, den);
				oy = rdiv(ny != aneg, mag * ady, den);
				if (dd == s2 || dd == df2)
					p.cnt = cit_pkg::CNT_ONE;
				else begin
					sq = 256'(isqrt((s2 - dd) * (dd - df2)));
					mx = rdiv(!ny, ady * sq, den);
					my = rdiv(nx, adx * sq, den);
					p.cnt = cit_pkg::CNT_TWO;
				end
			end
		end else begin
			if (dd == r0 * r0) begin
				p.cnt = cit_pkg::CNT_ONE;
				bx = 128'(q.x1);
				by = 128'(q.y1);
			end else if (dd > r0 * r0 && r0 == 0)
				p.cnt = cit_pkg::CNT_ONE;
			else if (dd > r0 * r0) begin
				sq = 256'(isqrt(dd - r0 * r0));
				ox = rdiv(nx, adx * r0 * r0, dd);
				oy = rdiv(ny, ady * r0 * r0, dd);
				mx = rdiv(!ny, ady * r0 * sq, dd);
				my = rdiv(nx, adx * r0 * sq, dd);
				p.cnt = cit_pkg::CNT_TWO;
			end
		end
		if (p.cnt != cit_pkg::CNT_NONE) begin
			p.p0x = clamp32(bx + ox + mx);
			p.p0y = clamp32(by + oy + my);
			p.p1x = clamp32(bx + ox - mx);
			p.p1y = clamp32(by + oy - my);
		end
		return p;
	endfunction

	function automatic logic signed [cit_pkg::CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $signed($urandom());
			1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			2: return $urandom_range(0, 1) ? cit_pkg::SAT_MAX : cit_pkg::SAT_MIN;
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int off;
		q.opcode = $urandom_range(0, 1) ? cit_pkg::OP_TANGENT : cit_pkg::OP_INTERSECT;
		q.x0 = rand_coord();
		q.y0 = rand_coord();
		q.r0 = $urandom_range(0, 7) == 0 ? cit_pkg::RW'($urandom()) :
			cit_pkg::RW'($urandom_range(0, 32'h0040_0000));
		q.r1 = $urandom_range(0, 7) == 0 ? cit_pkg::RW'($urandom()) :
			cit_pkg::RW'($urandom_range(0, 32'h0040_0000));
		if ($urandom_range(0, 9) < 7) begin
			// second centre close to the first so circles usually meet
			off = $urandom_range(0, 32'h0040_0000);
			q.x1 = q.x0 + $signed(off) - 32'sh0020_0000;
			q.y1 = q.y0 + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		end else begin
			q.x1 = rand_coord();
			q.y1 = rand_coord();
		end
		return q;
	endfunction

	function automatic query_t mk(input logic op, input int x0, input int y0,
			input int r0, input int x1, input int y1, input int r1);
		query_t q;
		q.opcode = op; q.x0 = x0; q.y0 = y0; q.r0 = cit_pkg::RW'(r0);
		q.x1 = x1; q.y1 = y1; q.r1 = cit_pkg::RW'(r1);
		return q;
	endfunction

	initial begin
		// two points, coincident, disjoint, contained, outer and inner tangency
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 0, 0, 5 << 16, 6 << 16, 0, 5 << 16));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 7, 9, 3 << 16, 7, 9, 3 << 16));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 0, 0, 1 << 16, 9 << 16, 0, 1 << 16));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 0, 0, 9 << 16, 1 << 16, 0, 1 << 16));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 0, 0, 2 << 16, 0, 5 << 16, 3 << 16));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 0, 0, 5 << 16, 0, -(2 << 16),
			3 << 16));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 0, 0, 3 << 16, -(4 << 16), 0,
			5 << 16));
		// tangent: outside, inside, on circle, zero radius
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 0, 0, 3 << 16, 5 << 16, 0, 0));
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 0, 0, 3 << 16, 1 << 16, 1 << 16, 0));
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 0, 0, 5 << 16, 3 << 16, 4 << 16, 0));
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 1, 2, 0, 7 << 16, -(3 << 16), 0));
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 2, 2, 0, 2, 2, 0));
		// extremes, saturation
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_queries.push_back(mk(cit_pkg::OP_TANGENT, 32'h8000_0000, 32'h8000_0000,
			1 << 16, 32'h7fff_ffff, 32'h7fff_ffff, 0));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, 32'h7fff_ffff, 0, 32'h7fff_ffff,
			32'h8000_0000, 0, 32'h7fff_ffff));
		pending_queries.push_back(mk(cit_pkg::OP_INTERSECT, -1, -1, 32'h4000_0000, 1, 1,
			32'h4000_0000));
		for (int i = 0; i < 1900; i++)
			pending_queries.push_back(rand_query());
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query.valid <= 1'b0;
			query.opcode <= cit_pkg::OP_INTERSECT;
			query.first_x <= '0;
			query.first_y <= '0;
			query.first_radius <= '0;
			query.second_x <= '0;
			query.second_y <= '0;
			query.second_radius <= '0;
		end else if (!query.valid || query.ready) begin
			if (query.valid)
				expected_points.push_back(solve_circles({query.opcode, query.first_x,
					query.first_y, query.first_radius, query.second_x,
					query.second_y, query.second_radius}));
			if (pending_queries.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
				query_t q;
				q = pending_queries.pop_front();
				query.valid <= 1'b1;
				query.opcode <= q.opcode;
				query.first_x <= q.x0;
				query.first_y <= q.y0;
				query.first_radius <= q.r0;
				query.second_x <= q.x1;
				query.second_y <= q.y1;
				query.second_radius <= q.r1;
			end else begin
				query.valid <= 1'b0;
				if (pending_queries.size() == 0)
					stim_done <= 1'b1;
			end
		end
	end

	// receiver stalls; one long hold-off while the sender keeps going
	int accepted_results = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_cycles <= 0;
			held <= 1'b0;
			calm <= 1'b0;
		end else begin
			if (accepted_results >= 300 && !held) begin
				hold_cycles <= 400;
				held <= 1'b1;
			end else if (hold_cycles > 0)
				hold_cycles <= hold_cycles - 1;
			calm <= accepted_results >= 800 && accepted_results < 1200;
			result.ready <= hold_cycles <= 1 && (held || accepted_results < 300)
				&& (calm || $urandom_range(0, 99) >= 19);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			points_t got;
			points_t want;
			got = {result.point_count, result.first_point_x, result.first_point_y,
				result.second_point_x, result.second_point_y};
			accepted_results <= accepted_results + 1;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected transfer %h", $time, got);
				errors++;
			end else begin
				want = expected_points.pop_front();
				if (got.cnt !== want.cnt) begin
					$display("%0t: point_count exp %0d got %0d", $time, want.cnt, got.cnt);
					errors++;
				end
				if (got.p0x !== want.p0x) begin
					$display("%0t: first_point_x exp %0d got %0d", $time, want.p0x, got.p0x);
					errors++;
				end
				if (got.p0y !== want.p0y) begin
					$display("%0t: first_point_y exp %0d got %0d", $time, want.p0y, got.p0y);
					errors++;
				end
				if (got.p1x !== want.p1x) begin
					$display("%0t: second_point_x exp %0d got %0d", $time, want.p1x, got.p1x);
					errors++;
				end
				if (got.p1y !== want.p1y) begin
					$display("%0t: second_point_y exp %0d got %0d", $time, want.p1y, got.p1y);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
	end

	initial begin
		wait (arst_n);
		while (!(stim_done && !query.valid && expected_points.size() == 0)
				&& idle_count < WATCHDOG)
			@(posedge clk);
		if (idle_count >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end else begin
			repeat (150) @(posedge clk);
			if (errors == 0)
				$display("status: pass");
			else
				$display("status: fail");
			$finish;
		end
	end
endmodule
`default_nettype wire
